FILE: design/gtae_pkg.sv
// Package for the gate/toggle envelope generator and stereo VCA.
// Holds the default widths, register indexes, stage and controller codes and the
// command and status bundles shared by the controller and the datapath.
package gtae_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int TIME_WIDTH_DEF      = 20;
  localparam int LEVEL_FRAC_BITS_DEF = 30;

  localparam int SUS_WIDTH      = 17;
  localparam int ENV_WIDTH      = 17;
  localparam int ENV_FRAC_BITS  = 16;
  localparam int CFG_ADDR_WIDTH = 3;

  localparam logic [SUS_WIDTH-1:0] SUS_FULL = 17'h10000;

  localparam int MIN_ENV_RESET = 48;
  localparam int MAX_ENV_RESET = 480000;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_FLIP_MODE       = 3'd0,
    REG_RESET_ENABLED   = 3'd1,
    REG_LEFT_CONNECTED  = 3'd2,
    REG_RIGHT_CONNECTED = 3'd3,
    REG_MIN_ENV_SAMPLES = 3'd4,
    REG_MAX_ENV_SAMPLES = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STG_STOP    = 2'd0,
    STG_ATTACK  = 2'd1,
    STG_SUSTAIN = 2'd2,
    STG_RELEASE = 2'd3
  } stage_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_LEVEL,
    S_MUL,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic slope_load;
    logic level_upd;
    logic mul;
    logic load_out;
  } gtae_cmd_t;

  typedef struct packed {
    logic div_need;
    logic div_busy;
    logic out_free;
  } gtae_sts_t;

endpackage

FILE: design/gtae_div.sv
// Restoring serial divider that produces one quotient bit per cycle.
// Used by the envelope datapath for the ramp slope; no package dependencies.
module gtae_div #(
  parameter int NUM_WIDTH = 31,
  parameter int DEN_WIDTH = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] num,
  input  logic [DEN_WIDTH-1:0] den,
  output logic                 busy,
  output logic [NUM_WIDTH-1:0] quot
);

  localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

  logic                 busy_r, busy_nxt;
  logic [CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [NUM_WIDTH-1:0] quot_r, quot_nxt;
  logic [DEN_WIDTH-1:0] rem_r, rem_nxt;
  logic [DEN_WIDTH-1:0] den_r, den_nxt;
  logic [DEN_WIDTH:0]   trial;
  logic                 fits;

  always_comb begin
    trial    = {rem_r, quot_r[NUM_WIDTH-1]};
    fits     = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      quot_nxt = {quot_r[NUM_WIDTH-2:0], fits};
      rem_nxt  = fits ? DEN_WIDTH'(trial - {1'b0, den_r}) : trial[DEN_WIDTH-1:0];
      cnt_nxt  = cnt_r + CNT_WIDTH'(1);
      if (cnt_r == CNT_WIDTH'(NUM_WIDTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign busy = busy_r;
  assign quot = quot_r;

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> den_r != '0)
    else $error("divider running with a zero divisor");

endmodule

FILE: design/gtae_datapath.sv
// Datapath of the envelope generator: configuration registers, trigger and gating
// logic, slope divider, level accumulator, VCA multipliers and the output register.
// Depends on gtae_pkg and gtae_div.
module gtae_datapath
  import gtae_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int TIME_WIDTH      = TIME_WIDTH_DEF,
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gtae_cmd_t                      cmd,
  output gtae_sts_t                      sts,
  input  logic                           cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0]      cfg_addr,
  input  logic [TIME_WIDTH-1:0]          cfg_wdata,
  input  logic                           in_trig_high,
  input  logic                           in_rst_high,
  input  logic [TIME_WIDTH-1:0]          in_attack_samples,
  input  logic [TIME_WIDTH-1:0]          in_release_samples,
  input  logic [SUS_WIDTH-1:0]           in_sustain_level,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right_in,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_out,
  output logic                           out_gate_out,
  output logic [ENV_WIDTH-1:0]           out_env_level
);

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam int PW = SAMPLE_WIDTH + LW;
  localparam int SUS_SHIFT = LEVEL_FRAC_BITS - ENV_FRAC_BITS;
  localparam logic [LW-1:0] ONE_LEVEL = LW'(1) << LEVEL_FRAC_BITS;
  localparam logic [SAMPLE_WIDTH-1:0] FULL_SCALE = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  logic                  flip_mode_r, reset_en_r, left_conn_r, right_conn_r;
  logic [TIME_WIDTH-1:0] min_env_r, max_env_r;

  logic                    trig_in_r, rst_in_r;
  logic [TIME_WIDTH-1:0]   att_r, rel_r;
  logic [SUS_WIDTH-1:0]    sus_r;
  logic [SAMPLE_WIDTH-1:0] left_r, right_r;

  logic          gating_r, gating_nxt;
  stage_t        stage_r, stage_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [LW-1:0] slope_r, slope_nxt;
  logic          prev_trig_r, prev_trig_nxt;
  logic          prev_rst_r, prev_rst_nxt;
  logic          trig_state_r, trig_state_nxt;

  logic [PW-1:0] prod_l_r, prod_r_r;
  logic          neg_l_r, neg_r_r;

  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] left_out_r, right_out_r;
  logic                    gate_out_r;
  logic [ENV_WIDTH-1:0]    env_out_r;

  logic                  rst_edge, trig_ev, start_gate, end_gate, div_need, out_free;
  logic                  gating_pre;
  stage_t                stage_pre;
  logic [LW-1:0]         level_pre;
  logic [LW-1:0]         div_num, div_quot;
  logic [TIME_WIDTH-1:0] max_eff, t_sel, t_clamp, div_den;
  logic                  div_busy;

  logic [SUS_WIDTH-1:0]    sus_clamped;
  logic [LW-1:0]           sus_lvl;
  logic [LW:0]             att_sum;
  logic [SAMPLE_WIDTH-1:0] src_l, src_r, mag_l, mag_r, res_l, res_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_mode_r  <= 1'b1;
      reset_en_r   <= 1'b0;
      left_conn_r  <= 1'b0;
      right_conn_r <= 1'b0;
      min_env_r    <= TIME_WIDTH'(MIN_ENV_RESET);
      max_env_r    <= TIME_WIDTH'(MAX_ENV_RESET);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FLIP_MODE:       flip_mode_r  <= cfg_wdata[0];
        REG_RESET_ENABLED:   reset_en_r   <= cfg_wdata[0];
        REG_LEFT_CONNECTED:  left_conn_r  <= cfg_wdata[0];
        REG_RIGHT_CONNECTED: right_conn_r <= cfg_wdata[0];
        REG_MIN_ENV_SAMPLES: min_env_r    <= cfg_wdata;
        REG_MAX_ENV_SAMPLES: max_env_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      trig_in_r <= in_trig_high;
      rst_in_r  <= in_rst_high;
      att_r     <= in_attack_samples;
      rel_r     <= in_release_samples;
      sus_r     <= in_sustain_level;
      left_r    <= in_left_in;
      right_r   <= in_right_in;
    end
  end

  // Trigger, reset edge and gating decision.
  always_comb begin
    rst_edge   = flip_mode_r && reset_en_r && rst_in_r && !prev_rst_r;
    gating_pre = rst_edge ? 1'b0 : gating_r;
    stage_pre  = rst_edge ? STG_STOP : stage_r;
    level_pre  = rst_edge ? '0 : level_r;
    if (!flip_mode_r) begin
      if (trig_in_r && !prev_trig_r) begin
        trig_ev = 1'b1;
      end else if (!trig_in_r && prev_trig_r) begin
        trig_ev = 1'b0;
      end else begin
        trig_ev = trig_state_r;
      end
    end else begin
      trig_ev = trig_in_r && !prev_trig_r;
    end
    start_gate = !gating_pre && trig_ev;
    end_gate   = gating_pre && (flip_mode_r ? trig_ev : !trig_ev);
    div_need   = (start_gate && (att_r >= min_env_r)) || (end_gate && (rel_r >= min_env_r));
    if (start_gate) begin
      div_num = (level_pre < ONE_LEVEL) ? ONE_LEVEL - level_pre : '0;
      t_sel   = att_r;
    end else begin
      div_num = level_pre;
      t_sel   = rel_r;
    end
    max_eff = (max_env_r == '0) ? TIME_WIDTH'(1) : max_env_r;
    t_clamp = (t_sel > max_eff) ? max_eff : t_sel;
    div_den = (t_clamp == '0) ? TIME_WIDTH'(1) : t_clamp;
  end

  // Level update for the current stage.
  always_comb begin
    sus_clamped = (sus_r > SUS_FULL) ? SUS_FULL : sus_r;
    sus_lvl     = LW'(sus_clamped) << SUS_SHIFT;
    att_sum     = {1'b0, level_r} + {1'b0, slope_r};
  end

  always_comb begin
    gating_nxt     = gating_r;
    stage_nxt      = stage_r;
    level_nxt      = level_r;
    slope_nxt      = slope_r;
    prev_trig_nxt  = prev_trig_r;
    prev_rst_nxt   = prev_rst_r;
    trig_state_nxt = trig_state_r;
    if (cmd.eval) begin
      trig_state_nxt = trig_ev;
      prev_trig_nxt  = trig_in_r;
      if (flip_mode_r && reset_en_r) begin
        prev_rst_nxt = rst_in_r;
      end
      level_nxt  = level_pre;
      gating_nxt = gating_pre;
      stage_nxt  = stage_pre;
      if (start_gate) begin
        gating_nxt = 1'b1;
        stage_nxt  = (att_r < min_env_r) ? STG_SUSTAIN : STG_ATTACK;
      end else if (end_gate) begin
        gating_nxt = 1'b0;
        stage_nxt  = (rel_r < min_env_r) ? STG_STOP : STG_RELEASE;
      end
    end
    if (cmd.slope_load) begin
      slope_nxt = div_quot;
    end
    if (cmd.level_upd) begin
      case (stage_r)
        STG_ATTACK: begin
          if (att_sum >= {1'b0, sus_lvl}) begin
            level_nxt = sus_lvl;
            stage_nxt = STG_SUSTAIN;
          end else begin
            level_nxt = att_sum[LW-1:0];
          end
        end
        STG_SUSTAIN: level_nxt = sus_lvl;
        STG_RELEASE: begin
          if (slope_r > level_r) begin
            level_nxt = '0;
            stage_nxt = STG_STOP;
          end else begin
            level_nxt = level_r - slope_r;
          end
        end
        default: level_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gating_r     <= 1'b0;
      stage_r      <= STG_STOP;
      level_r      <= '0;
      slope_r      <= '0;
      prev_trig_r  <= 1'b0;
      prev_rst_r   <= 1'b0;
      trig_state_r <= 1'b0;
    end else begin
      gating_r     <= gating_nxt;
      stage_r      <= stage_nxt;
      level_r      <= level_nxt;
      slope_r      <= slope_nxt;
      prev_trig_r  <= prev_trig_nxt;
      prev_rst_r   <= prev_rst_nxt;
      trig_state_r <= trig_state_nxt;
    end
  end

  gtae_div #(
    .NUM_WIDTH (LW),
    .DEN_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.eval && div_need),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // VCA: magnitude times level, truncated toward zero.
  always_comb begin
    src_l = left_conn_r ? left_r : FULL_SCALE;
    src_r = right_conn_r ? right_r : FULL_SCALE;
    mag_l = src_l[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-src_l) : src_l;
    mag_r = src_r[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-src_r) : src_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_l_r <= PW'(mag_l) * PW'(level_r);
      prod_r_r <= PW'(mag_r) * PW'(level_r);
      neg_l_r  <= src_l[SAMPLE_WIDTH-1];
      neg_r_r  <= src_r[SAMPLE_WIDTH-1];
    end
  end

  always_comb begin
    res_l    = prod_l_r[LEVEL_FRAC_BITS +: SAMPLE_WIDTH];
    res_r    = prod_r_r[LEVEL_FRAC_BITS +: SAMPLE_WIDTH];
    out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      left_out_r  <= neg_l_r ? SAMPLE_WIDTH'(-res_l) : res_l;
      right_out_r <= neg_r_r ? SAMPLE_WIDTH'(-res_r) : res_r;
      gate_out_r  <= gating_r;
      env_out_r   <= level_r[SUS_SHIFT +: ENV_WIDTH];
    end
  end

  assign sts.div_need = div_need;
  assign sts.div_busy = div_busy;
  assign sts.out_free = out_free;

  assign out_valid     = out_valid_r;
  assign out_left_out  = left_out_r;
  assign out_right_out = right_out_r;
  assign out_gate_out  = gate_out_r;
  assign out_env_level = env_out_r;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= ONE_LEVEL)
    else $error("envelope level above full scale");

  a_gating_stage: assert property (@(posedge clk) disable iff (!rst_n)
    gating_r == ((stage_r == STG_ATTACK) || (stage_r == STG_SUSTAIN)))
    else $error("gating and envelope stage disagree");

  a_stop_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.level_upd) && (stage_r == STG_STOP) |-> level_r == '0)
    else $error("stopped envelope left with a non-zero level");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("output register overwritten before its beat was taken");

endmodule

FILE: design/gtae_ctrl.sv
// Controller state machine that sequences one beat through evaluation, slope
// division when needed, level update, multiplication and output. Depends on gtae_pkg.
module gtae_ctrl
  import gtae_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  gtae_sts_t sts,
  output gtae_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = sts.div_need ? S_DIV : S_LEVEL;
      S_DIV:   if (!sts.div_busy) state_nxt = S_LEVEL;
      S_LEVEL: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_OUT;
      S_OUT:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_EVAL:  cmd.eval       = 1'b1;
      S_DIV:   cmd.slope_load = !sts.div_busy;
      S_LEVEL: cmd.level_upd  = 1'b1;
      S_MUL:   cmd.mul        = 1'b1;
      S_OUT:   cmd.load_out   = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/gate_toggle_asr_envelope_vca.sv
// Gate/toggle linear attack-sustain-release envelope with a stereo VCA.
// An accepted input beat passes through evaluation, a slope division when needed, level
// update, multiplication and the output register; a division is needed when gating starts
// or ends with a ramp and runs in the serial slope divider, one quotient bit per cycle.
// A new beat is not taken until the previous one has been loaded into the output register.
// Reset is synchronous and active low; it restores the register defaults and the idle envelope.
module gate_toggle_asr_envelope_vca
  import gtae_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int TIME_WIDTH      = TIME_WIDTH_DEF,
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0]      cfg_addr,
  input  logic [TIME_WIDTH-1:0]          cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_trig_high,
  input  logic                           in_rst_high,
  input  logic [TIME_WIDTH-1:0]          in_attack_samples,
  input  logic [TIME_WIDTH-1:0]          in_release_samples,
  input  logic [SUS_WIDTH-1:0]           in_sustain_level,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_out,
  output logic                           out_gate_out,
  output logic [ENV_WIDTH-1:0]           out_env_level
);

  gtae_cmd_t cmd;
  gtae_sts_t sts;

  gtae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtae_datapath #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .TIME_WIDTH      (TIME_WIDTH),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_trig_high       (in_trig_high),
    .in_rst_high        (in_rst_high),
    .in_attack_samples  (in_attack_samples),
    .in_release_samples (in_release_samples),
    .in_sustain_level   (in_sustain_level),
    .in_left_in         (in_left_in),
    .in_right_in        (in_right_in),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_left_out       (out_left_out),
    .out_right_out      (out_right_out),
    .out_gate_out       (out_gate_out),
    .out_env_level      (out_env_level)
  );

endmodule
